@@ rtl/ipv4acl_pkg.sv @@
// ----------------------------------------------------------------------------
// ipv4acl_pkg
// Shared types and constants of the first-match IPv4 access list.
// ----------------------------------------------------------------------------
package ipv4acl_pkg;

    localparam int DEFAULT_RULE_SLOTS = 16;
    localparam int ADDR_W             = 32;
    localparam int LEN_W              = 16;
    localparam int HIT_W              = 4;

    localparam logic [LEN_W-1:0] MIN_HEADER_BYTES = 16'd20;

    typedef enum logic {
        OP_CHECK  = 1'b0,
        OP_APPEND = 1'b1
    } t_op;

    // one stored rule, values already masked
    typedef struct packed {
        logic              verdict;
        logic [ADDR_W-1:0] src;
        logic [ADDR_W-1:0] src_care;
        logic [ADDR_W-1:0] dst;
        logic [ADDR_W-1:0] dst_care;
    } t_rule;

    // lookup token handed from cell to cell
    typedef struct packed {
        logic              vld;
        logic [ADDR_W-1:0] src;
        logic [ADDR_W-1:0] dst;
        logic              found;
        logic              verdict;
        logic [HIT_W-1:0]  hit;
    } t_probe;

endpackage

@@ rtl/ipv4acl_top.sv @@
// ----------------------------------------------------------------------------
// ipv4_first_match_acl_top
// First-match IPv4 access list built as a row of rule cells.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken when start is high and busy is low. i_operation selects
//   append (store a rule in the next free slot) or check (look up the
//   packet addresses). Every item gives exactly one result, shown for one
//   cycle with o_done high; the receiver must take it then.
//   Append and short-packet checks: result in the cycle after the transfer,
//   and busy stays low, so one such item per cycle while no full check runs.
//   Full checks: the lookup token walks the row of RULE_SLOTS cells, one
//   cell per cycle, registered in each cell, so the result appears once the
//   token leaves the last cell. busy is high meanwhile and drops after the
//   result, so no new item is taken while a check is in the row.
//   Reset empties the table (rule count to zero) and drops any lookup in
//   flight; rule contents are not cleared, unused slots are never read.
//   An append to a full table is refused and o_table_full is set.
// ----------------------------------------------------------------------------
module ipv4_first_match_acl_top #(
    parameter int RULE_SLOTS = ipv4acl_pkg::DEFAULT_RULE_SLOTS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             i_operation,
    input  logic [ipv4acl_pkg::LEN_W-1:0]    i_packet_length,
    input  logic [ipv4acl_pkg::ADDR_W-1:0]   i_packet_src,
    input  logic [ipv4acl_pkg::ADDR_W-1:0]   i_packet_dst,
    input  logic                             i_rule_verdict,
    input  logic [ipv4acl_pkg::ADDR_W-1:0]   i_rule_src,
    input  logic [ipv4acl_pkg::ADDR_W-1:0]   i_rule_src_mask,
    input  logic [ipv4acl_pkg::ADDR_W-1:0]   i_rule_dst,
    input  logic [ipv4acl_pkg::ADDR_W-1:0]   i_rule_dst_mask,
    output logic                             o_done,
    output logic                             o_short_packet,
    output logic                             o_matched,
    output logic                             o_verdict,
    output logic [ipv4acl_pkg::HIT_W-1:0]    o_hit_index,
    output logic                             o_table_full
);

    localparam int CW = $clog2(RULE_SLOTS + 1);

    ipv4acl_pkg::t_probe w_chain [RULE_SLOTS+1];
    ipv4acl_pkg::t_rule  w_rule;

    logic          w_accept;
    logic          w_append;
    logic          w_short;
    logic          w_lookup;
    logic          w_full;
    logic          w_wr_en;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_busy;
    logic          n_busy;
    logic          r_res_vld;
    logic          r_short;
    logic          r_full;

    assign w_accept = start && !r_busy;
    assign w_append = w_accept && (i_operation == ipv4acl_pkg::OP_APPEND);
    assign w_short  = w_accept && (i_operation == ipv4acl_pkg::OP_CHECK)
                      && (i_packet_length < ipv4acl_pkg::MIN_HEADER_BYTES);
    assign w_lookup = w_accept && (i_operation == ipv4acl_pkg::OP_CHECK)
                      && !(i_packet_length < ipv4acl_pkg::MIN_HEADER_BYTES);
    assign w_full   = r_count == CW'(RULE_SLOTS);
    assign w_wr_en  = w_append && !w_full;

    assign w_rule.verdict  = i_rule_verdict;
    assign w_rule.src      = i_rule_src & i_rule_src_mask;
    assign w_rule.src_care = i_rule_src_mask;
    assign w_rule.dst      = i_rule_dst & i_rule_dst_mask;
    assign w_rule.dst_care = i_rule_dst_mask;

    assign w_chain[0].vld     = w_lookup;
    assign w_chain[0].src     = i_packet_src;
    assign w_chain[0].dst     = i_packet_dst;
    assign w_chain[0].found   = 1'b0;
    assign w_chain[0].verdict = 1'b0;
    assign w_chain[0].hit     = '0;

    for (genvar k = 0; k < RULE_SLOTS; k++) begin : g_cell
        ipv4acl_cell #(
            .RULE_SLOTS (RULE_SLOTS),
            .CELL_IDX   (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_wr_en (w_wr_en),
            .i_rule  (w_rule),
            .i_count (r_count),
            .i_probe (w_chain[k]),
            .o_probe (w_chain[k+1])
        );
    end

    assign n_count = w_wr_en ? r_count + CW'(1) : r_count;

    // busy from lookup transfer until the token leaves the last cell
    always_comb begin
        n_busy = r_busy;
        if (w_lookup) begin
            n_busy = 1'b1;
        end else if (w_chain[RULE_SLOTS].vld) begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_busy    <= 1'b0;
            r_res_vld <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_busy    <= n_busy;
            r_res_vld <= w_append || w_short;
        end
    end

    always_ff @(posedge i_clk) begin
        r_short <= w_short;
        r_full  <= w_append && w_full;
    end

    assign busy   = r_busy;
    assign o_done = r_res_vld || w_chain[RULE_SLOTS].vld;

    always_comb begin
        if (w_chain[RULE_SLOTS].vld) begin
            o_short_packet = 1'b0;
            o_matched      = w_chain[RULE_SLOTS].found;
            o_verdict      = w_chain[RULE_SLOTS].found && w_chain[RULE_SLOTS].verdict;
            o_hit_index    = w_chain[RULE_SLOTS].found ? w_chain[RULE_SLOTS].hit : '0;
            o_table_full   = 1'b0;
        end else begin
            o_short_packet = r_short;
            o_matched      = 1'b0;
            o_verdict      = 1'b0;
            o_hit_index    = '0;
            o_table_full   = r_full;
        end
    end

    // quick results and lookup results never land in the same cycle
    a_one_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_res_vld && w_chain[RULE_SLOTS].vld))
        else $error("two results in one cycle");

    a_lookup_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_lookup |=> r_busy)
        else $error("lookup started without busy");

    a_busy_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> $past(w_chain[RULE_SLOTS].vld))
        else $error("busy dropped without a lookup result");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(RULE_SLOTS))
        else $error("rule count beyond table size");

endmodule

@@ rtl/ipv4acl_cell.sv @@
// ----------------------------------------------------------------------------
// ipv4acl_cell
// One rule slot: holds a rule and tests the passing lookup token against it.
// ----------------------------------------------------------------------------
module ipv4acl_cell #(
    parameter int RULE_SLOTS = ipv4acl_pkg::DEFAULT_RULE_SLOTS,
    parameter int CELL_IDX   = 0
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_wr_en,
    input  ipv4acl_pkg::t_rule                 i_rule,
    input  logic [$clog2(RULE_SLOTS+1)-1:0]    i_count,
    input  ipv4acl_pkg::t_probe                i_probe,
    output ipv4acl_pkg::t_probe                o_probe
);

    localparam int CW = $clog2(RULE_SLOTS + 1);

    ipv4acl_pkg::t_rule  r_rule;
    ipv4acl_pkg::t_probe r_probe;
    ipv4acl_pkg::t_probe n_probe;

    logic w_active;
    logic w_src_ok;
    logic w_dst_ok;

    // slot takes the rule when it is the next free one
    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_count == CW'(CELL_IDX))) begin
            r_rule <= i_rule;
        end
    end

    // zero stored value is a wildcard
    assign w_active = CW'(CELL_IDX) < i_count;
    assign w_src_ok = (r_rule.src == '0) || ((i_probe.src & r_rule.src_care) == r_rule.src);
    assign w_dst_ok = (r_rule.dst == '0) || ((i_probe.dst & r_rule.dst_care) == r_rule.dst);

    always_comb begin
        n_probe = i_probe;
        if (i_probe.vld && !i_probe.found && w_active && w_src_ok && w_dst_ok) begin
            n_probe.found   = 1'b1;
            n_probe.verdict = r_rule.verdict;
            n_probe.hit     = ipv4acl_pkg::HIT_W'(CELL_IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe <= '0;
        end else begin
            r_probe <= n_probe;
        end
    end

    assign o_probe = r_probe;

endmodule

@@ dv/tb_ipv4_first_match_acl_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ipv4_first_match_acl_top
// Self-checking bench for the first-match IPv4 access list.
// A directed opening covers short headers, empty-table lookups and
// first-match ordering. Random traffic then fills the rule table and keeps
// appending after it is full. Most lookups aim at stored rules. Every done
// strobe is checked against an in-bench classifier. The sender works in
// random bursts with random gaps.
// ----------------------------------------------------------------------------
module tb_ipv4_first_match_acl_top;

    localparam int SLOTS        = ipv4acl_pkg::DEFAULT_RULE_SLOTS;
    localparam int AW           = ipv4acl_pkg::ADDR_W;
    localparam int LW           = ipv4acl_pkg::LEN_W;
    localparam int HW           = ipv4acl_pkg::HIT_W;
    localparam int RANDOM_ITEMS = 400;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct {
        ipv4acl_pkg::t_op op;
        logic [LW-1:0]    len;
        logic [AW-1:0]    pkt_src;
        logic [AW-1:0]    pkt_dst;
        logic             rule_verdict;
        logic [AW-1:0]    rule_src;
        logic [AW-1:0]    rule_src_care;
        logic [AW-1:0]    rule_dst;
        logic [AW-1:0]    rule_dst_care;
    } t_acl_item;

    typedef struct packed {
        logic          short_packet;
        logic          matched;
        logic          verdict;
        logic [HW-1:0] hit_index;
        logic          table_full;
    } t_acl_outcome;

    logic          i_clk           = 1'b0;
    logic          i_rst_n         = 1'b0;
    logic          start           = 1'b0;
    logic          busy;
    logic          i_operation     = 1'b0;
    logic [LW-1:0] i_packet_length = '0;
    logic [AW-1:0] i_packet_src    = '0;
    logic [AW-1:0] i_packet_dst    = '0;
    logic          i_rule_verdict  = 1'b0;
    logic [AW-1:0] i_rule_src      = '0;
    logic [AW-1:0] i_rule_src_mask = '0;
    logic [AW-1:0] i_rule_dst      = '0;
    logic [AW-1:0] i_rule_dst_mask = '0;
    logic          o_done;
    logic          o_short_packet;
    logic          o_matched;
    logic          o_verdict;
    logic [HW-1:0] o_hit_index;
    logic          o_table_full;

    t_acl_item    acl_items[$];
    t_acl_outcome expected_outcomes[$];

    // classifier state
    ipv4acl_pkg::t_rule rule_bank[SLOTS];
    int                 rule_count = 0;

    // rules as the stimulus builder sees them, used to aim lookups
    logic [AW-1:0] plan_src_val[SLOTS];
    logic [AW-1:0] plan_src_care[SLOTS];
    logic [AW-1:0] plan_dst_val[SLOTS];
    logic [AW-1:0] plan_dst_care[SLOTS];
    int            plan_count = 0;

    t_acl_item    drv_item;
    t_acl_item    seen_item;
    t_acl_outcome want;
    logic         took_item      = 1'b0;
    int           accepted_count = 0;
    int           total_items    = 0;
    int           burst_left     = 1;
    int           idle_left      = 0;
    int           fail_count     = 0;
    int           cycle_count    = 0;

    ipv4_first_match_acl_top #(
        .RULE_SLOTS(SLOTS)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_packet_length(i_packet_length),
        .i_packet_src   (i_packet_src),
        .i_packet_dst   (i_packet_dst),
        .i_rule_verdict (i_rule_verdict),
        .i_rule_src     (i_rule_src),
        .i_rule_src_mask(i_rule_src_mask),
        .i_rule_dst     (i_rule_dst),
        .i_rule_dst_mask(i_rule_dst_mask),
        .o_done         (o_done),
        .o_short_packet (o_short_packet),
        .o_matched      (o_matched),
        .o_verdict      (o_verdict),
        .o_hit_index    (o_hit_index),
        .o_table_full   (o_table_full)
    );

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        fail_count++;
    endtask

    function automatic logic [AW-1:0] pick_mask();
        int n;
        case ($urandom_range(0, 9))
            0: begin
                return '0;
            end
            1, 2, 3, 4, 5: begin
                n = $urandom_range(0, 32);
                return 32'hFFFF_FFFF << (32 - n);
            end
            default: begin
                return $urandom;
            end
        endcase
    endfunction

    task automatic queue_append(input logic verdict, input logic [AW-1:0] src,
                                input logic [AW-1:0] smask,
                                input logic [AW-1:0] dst,
                                input logic [AW-1:0] dmask);
        t_acl_item it;
        it.op            = ipv4acl_pkg::OP_APPEND;
        it.len           = LW'($urandom_range(0, 65535));
        it.pkt_src       = $urandom;
        it.pkt_dst       = $urandom;
        it.rule_verdict  = verdict;
        it.rule_src      = src;
        it.rule_src_care = smask;
        it.rule_dst      = dst;
        it.rule_dst_care = dmask;
        acl_items.push_back(it);
        if (plan_count < SLOTS) begin
            plan_src_val[plan_count]  = src & smask;
            plan_src_care[plan_count] = smask;
            plan_dst_val[plan_count]  = dst & dmask;
            plan_dst_care[plan_count] = dmask;
            plan_count++;
        end
    endtask

    task automatic queue_check(input logic [LW-1:0] len, input logic [AW-1:0] src,
                               input logic [AW-1:0] dst);
        t_acl_item it;
        it.op            = ipv4acl_pkg::OP_CHECK;
        it.len           = len;
        it.pkt_src       = src;
        it.pkt_dst       = dst;
        it.rule_verdict  = 1'($urandom_range(0, 1));
        it.rule_src      = $urandom;
        it.rule_src_care = $urandom;
        it.rule_dst      = $urandom;
        it.rule_dst_care = $urandom;
        acl_items.push_back(it);
    endtask

    // updates the rule bank and returns what the block should report
    function automatic t_acl_outcome classify(input t_acl_item it);
        t_acl_outcome res;
        logic         src_ok;
        logic         dst_ok;
        int           k;
        res = '0;
        if (it.op == ipv4acl_pkg::OP_APPEND) begin
            if (rule_count >= SLOTS) begin
                res.table_full = 1'b1;
            end else begin
                rule_bank[rule_count].verdict  = it.rule_verdict;
                rule_bank[rule_count].src      = it.rule_src & it.rule_src_care;
                rule_bank[rule_count].src_care = it.rule_src_care;
                rule_bank[rule_count].dst      = it.rule_dst & it.rule_dst_care;
                rule_bank[rule_count].dst_care = it.rule_dst_care;
                rule_count++;
            end
        end else if (it.len < ipv4acl_pkg::MIN_HEADER_BYTES) begin
            res.short_packet = 1'b1;
        end else begin
            for (k = 0; k < rule_count; k++) begin
                // a zero stored value is a wildcard for that side
                src_ok = (rule_bank[k].src == '0) ||
                         ((it.pkt_src & rule_bank[k].src_care) == rule_bank[k].src);
                dst_ok = (rule_bank[k].dst == '0) ||
                         ((it.pkt_dst & rule_bank[k].dst_care) == rule_bank[k].dst);
                if (!res.matched && src_ok && dst_ok) begin
                    res.matched   = 1'b1;
                    res.verdict   = rule_bank[k].verdict;
                    res.hit_index = k[HW-1:0];
                end
            end
        end
        return res;
    endfunction

    // driver: a new item goes out once the previous one was taken
    always @(negedge i_clk) begin
        if (i_rst_n && (!start || took_item)) begin
            if (idle_left > 0) begin
                start <= 1'b0;
                idle_left = idle_left - 1;
            end else if (acl_items.size() > 0) begin
                drv_item = acl_items.pop_front();
                i_operation     <= drv_item.op;
                i_packet_length <= drv_item.len;
                i_packet_src    <= drv_item.pkt_src;
                i_packet_dst    <= drv_item.pkt_dst;
                i_rule_verdict  <= drv_item.rule_verdict;
                i_rule_src      <= drv_item.rule_src;
                i_rule_src_mask <= drv_item.rule_src_care;
                i_rule_dst      <= drv_item.rule_dst;
                i_rule_dst_mask <= drv_item.rule_dst_care;
                start           <= 1'b1;
                burst_left = burst_left - 1;
                if (burst_left <= 0) begin
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                             : $urandom_range(1, 5);
                    idle_left  = $urandom_range(0, 8);
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor first, then predict the item taken at this edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            took_item <= 1'b0;
        end else begin
            if (o_done) begin
                if (expected_outcomes.size() == 0) begin
                    report_mismatch("result with nothing pending");
                end else begin
                    want = expected_outcomes.pop_front();
                    if (o_short_packet !== want.short_packet)
                        report_mismatch($sformatf("short_packet got %b want %b",
                                                  o_short_packet, want.short_packet));
                    if (o_matched !== want.matched)
                        report_mismatch($sformatf("matched got %b want %b",
                                                  o_matched, want.matched));
                    if (o_verdict !== want.verdict)
                        report_mismatch($sformatf("verdict got %b want %b",
                                                  o_verdict, want.verdict));
                    if (o_hit_index !== want.hit_index)
                        report_mismatch($sformatf("hit_index got %0d want %0d",
                                                  o_hit_index, want.hit_index));
                    if (o_table_full !== want.table_full)
                        report_mismatch($sformatf("table_full got %b want %b",
                                                  o_table_full, want.table_full));
                end
            end
            took_item <= start && !busy;
            if (start && !busy) begin
                seen_item.op            = ipv4acl_pkg::t_op'(i_operation);
                seen_item.len           = i_packet_length;
                seen_item.pkt_src       = i_packet_src;
                seen_item.pkt_dst       = i_packet_dst;
                seen_item.rule_verdict  = i_rule_verdict;
                seen_item.rule_src      = i_rule_src;
                seen_item.rule_src_care = i_rule_src_mask;
                seen_item.rule_dst      = i_rule_dst;
                seen_item.rule_dst_care = i_rule_dst_mask;
                expected_outcomes.push_back(classify(seen_item));
                accepted_count <= accepted_count + 1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int            n;
        int            k;
        logic [LW-1:0] len;
        logic [AW-1:0] src;
        logic [AW-1:0] dst;

        // empty table: short headers and lookups that find nothing
        queue_check(16'd20, 32'h0000_0000, 32'h0000_0000);
        queue_check(16'd0, 32'h0A00_0001, 32'hC0A8_0101);
        queue_check(16'd19, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_check(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // 10/8 from any destination, allow
        queue_append(1'b0, 32'h0A12_3456, 32'hFF00_0000, 32'hFFFF_FFFF, 32'h0000_0000);
        // host rule hidden behind the one above
        queue_append(1'b1, 32'h0A01_0203, 32'hFFFF_FFFF, 32'hC0A8_1234, 32'hFFFF_0000);
        // source wildcard through a zero mask, exact destination, deny
        queue_append(1'b1, 32'hDEAD_BEEF, 32'h0000_0000, 32'hC0A8_0101, 32'hFFFF_FFFF);
        queue_append(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_check(16'd20, 32'h0A01_0203, 32'hC0A8_0005);
        queue_check(16'd1500, 32'h0B00_0000, 32'hC0A8_0101);
        queue_check(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_check(16'd20, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
        queue_check(16'd19, 32'h0A01_0203, 32'hC0A8_0101);
        queue_check(16'd20, 32'h0000_0000, 32'h0000_0000);
        queue_check(16'd21, 32'h0AFF_FFFF, 32'h0000_0000);

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            // appends are frequent until the table fills, rare afterward
            if ($urandom_range(0, 99) < ((plan_count < SLOTS) ? 30 : 6)) begin
                queue_append(1'($urandom_range(0, 1)), $urandom, pick_mask(),
                             $urandom, pick_mask());
            end else begin
                len = ($urandom_range(0, 6) == 0) ? LW'($urandom_range(0, 19))
                                                  : LW'($urandom_range(20, 65535));
                src = $urandom;
                dst = $urandom;
                if (plan_count > 0 && $urandom_range(0, 9) < 7) begin
                    k   = $urandom_range(0, plan_count - 1);
                    src = plan_src_val[k] | (src & ~plan_src_care[k]);
                    dst = plan_dst_val[k] | (dst & ~plan_dst_care[k]);
                    // near misses
                    if ($urandom_range(0, 9) == 0)
                        src = src ^ (32'h1 << $urandom_range(0, 31));
                    if ($urandom_range(0, 9) == 0)
                        dst = dst ^ (32'h1 << $urandom_range(0, 31));
                end
                queue_check(len, src, dst);
            end
        end
        total_items = acl_items.size();

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_count < total_items)
            @(negedge i_clk);
        while (expected_outcomes.size() != 0)
            @(negedge i_clk);
        repeat (SLOTS + 4) @(negedge i_clk);

        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/ipv4acl_pkg.sv
rtl/ipv4acl_cell.sv
rtl/ipv4acl_top.sv
dv/tb_ipv4_first_match_acl_top.sv
